// ===== hdl/crcpl_pkg.sv =====
package crcpl_pkg;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_DONE  = 2'd2
  } result_kind_t;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [7:0]  CMD_LOAD  = 8'h4C;
  localparam logic [7:0]  CMD_DONE  = 8'h44;
  localparam logic [7:0]  REPLY_ACK = 8'h41;
  localparam logic [7:0]  REPLY_NAK = 8'h4E;

  localparam int unsigned RES_DEPTH = 3;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 2;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  mem_address;
    logic [7:0]   mem_data;
    logic [7:0]   reply_byte;
    logic [31:0]  total_bytes;
  } result_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/crc_checked_packet_loader.sv =====
// accepted items are registered, then any result is written to the result buffer
// throughput: one item per cycle if in_ready is high, set by crc update and phase step
// a three-entry result buffer keeps input flowing while out_ready is low
// reset (synchronous, rst_n low): base address, pointer, count and phase cleared,
// crc set to all ones, result buffer emptied
module crc_checked_packet_loader
  import crcpl_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_mem_address,
  output logic [7:0]  out_mem_data,
  output logic [7:0]  out_reply_byte,
  output logic [31:0] out_total_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_base_address
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  phase_t                phase_r, phase_nxt;
  logic [7:0]            len_r, len_nxt;
  logic [7:0]            offset_r, offset_nxt;
  logic [31:0]           crc_r, crc_nxt;
  logic [31:0]           crc_rcv_r, crc_rcv_nxt;
  logic [1:0]            crc_idx_r, crc_idx_nxt;
  logic [ADDR_WIDTH-1:0] wptr_r, wptr_nxt;
  logic [31:0]           count_r, count_nxt;
  logic [31:0]           base_r, base_nxt;
  logic [31:0]           crc_upd;
  logic [31:0]           crc_rcv_upd;
  logic [ADDR_WIDTH-1:0] addr;
  logic [63:0]           addr_ext;
  logic                  push;
  result_t               res;
  result_t               res_out;
  logic [RES_CNT_W-1:0]  fifo_level;
  logic [RES_CNT_W:0]    occupancy;

  assign occupancy = {1'b0, fifo_level} + {{RES_CNT_W{1'b0}}, in_vld_r};
  assign in_ready  = (occupancy < (RES_CNT_W + 1)'(RES_DEPTH));
  assign cfg_ready = 1'b1;

  assign crc_upd     = crc32_byte(crc_r, in_byte_r);
  assign crc_rcv_upd = crc_rcv_r | ({24'd0, in_byte_r} << {crc_idx_r, 3'b000});
  assign addr        = wptr_r + ADDR_WIDTH'(offset_r);
  assign addr_ext    = 64'(addr);

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    offset_nxt  = offset_r;
    crc_nxt     = crc_r;
    crc_rcv_nxt = crc_rcv_r;
    crc_idx_nxt = crc_idx_r;
    wptr_nxt    = wptr_r;
    count_nxt   = count_r;
    base_nxt    = base_r;
    push        = 1'b0;
    res         = '0;
    if (in_vld_r) begin
      unique case (phase_r)
        PH_CMD: begin
          if (in_byte_r == CMD_LOAD) begin
            crc_nxt     = crc32_byte(CRC_INIT, in_byte_r);
            crc_rcv_nxt = '0;
            crc_idx_nxt = '0;
            offset_nxt  = '0;
            len_nxt     = '0;
            phase_nxt   = PH_LEN;
          end else if (in_byte_r == CMD_DONE) begin
            push            = 1'b1;
            res.kind        = KIND_DONE;
            res.total_bytes = count_r;
            wptr_nxt        = ADDR_WIDTH'(base_r);
            count_nxt       = '0;
          end
        end
        PH_LEN: begin
          crc_nxt    = crc_upd;
          len_nxt    = in_byte_r;
          offset_nxt = '0;
          phase_nxt  = (in_byte_r == 8'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          crc_nxt         = crc_upd;
          push            = 1'b1;
          res.kind        = KIND_WRITE;
          res.mem_address = addr_ext[31:0];
          res.mem_data    = in_byte_r;
          offset_nxt      = offset_r + 8'd1;
          if ((offset_r + 8'd1) >= len_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          crc_rcv_nxt = crc_rcv_upd;
          crc_idx_nxt = crc_idx_r + 2'd1;
          if (crc_idx_r == 2'd3) begin
            phase_nxt = PH_CMD;
            push      = 1'b1;
            res.kind  = KIND_REPLY;
            if (crc_rcv_upd == ~crc_r) begin
              wptr_nxt       = wptr_r + ADDR_WIDTH'(len_r);
              count_nxt      = count_r + 32'(len_r);
              res.reply_byte = REPLY_ACK;
            end else begin
              res.reply_byte = REPLY_NAK;
            end
            crc_rcv_nxt = '0;
            crc_nxt     = CRC_INIT;
          end
        end
        default: phase_nxt = PH_CMD;
      endcase
    end
    if (cfg_valid && cfg_ready) begin
      base_nxt  = cfg_base_address;
      wptr_nxt  = ADDR_WIDTH'(cfg_base_address);
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      phase_r   <= PH_CMD;
      len_r     <= '0;
      offset_r  <= '0;
      crc_r     <= CRC_INIT;
      crc_rcv_r <= '0;
      crc_idx_r <= '0;
      wptr_r    <= '0;
      count_r   <= '0;
      base_r    <= '0;
    end else begin
      in_vld_r  <= in_valid && in_ready;
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      offset_r  <= offset_nxt;
      crc_r     <= crc_nxt;
      crc_rcv_r <= crc_rcv_nxt;
      crc_idx_r <= crc_idx_nxt;
      wptr_r    <= wptr_nxt;
      count_r   <= count_nxt;
      base_r    <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  crcpl_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .level     (fifo_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_out)
  );

  assign out_result_kind = res_out.kind;
  assign out_mem_address = res_out.mem_address;
  assign out_mem_data    = res_out.mem_data;
  assign out_reply_byte  = res_out.reply_byte;
  assign out_total_bytes = res_out.total_bytes;

endmodule

// ===== hdl/crcpl_out_fifo.sv =====
module crcpl_out_fifo
  import crcpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  result_t              push_data,
  output logic [RES_CNT_W-1:0] level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data
);

  result_t               mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0]  count_r, count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];
  assign level     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < RES_CNT_W'(RES_DEPTH)))
    else $error("result push into full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result buffer count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("result buffer count wrong after pop");

  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("result buffer count wrong after push");
`endif

endmodule
